[src/gsop_pkg.sv]
// ---------------------------------------------------------------------------
// gsop_pkg
// Shared types, widths and the strobe length table of the gate and strobe
// output port bank.
// ---------------------------------------------------------------------------
package gsop_pkg;

  // field widths
  localparam int PINS_W     = 8;
  localparam int CNT_W      = 5;
  localparam int SEL_W      = 3;
  localparam int TYPE_W     = 2;
  localparam int PORT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // number of entries in the strobe length table
  localparam int WIDTH_SEL_COUNT = 5;

  // request codes, the last one has no meaning and changes nothing
  typedef enum logic [TYPE_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_GATE   = 2'd1,
    REQ_STROBE = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_SEL   = 1'd0,
    CFG_INVERT_MASK = 1'd1
  } cfg_reg_t;

  // strobe length in ticks for a width selection
  function automatic logic [CNT_W-1:0] strobe_ticks(input logic [SEL_W-1:0] sel);
    logic [CNT_W-1:0] ticks;
    case (sel)
      3'd1:    ticks = 5'd10;
      3'd2:    ticks = 5'd15;
      3'd3:    ticks = 5'd20;
      3'd4:    ticks = 5'd25;
      default: ticks = 5'd5;
    endcase
    return ticks;
  endfunction

endpackage

[src/gsop_if.sv]
// ---------------------------------------------------------------------------
// gsop request and result channels
// Valid/ready channels carrying one request item and one result item.
// ---------------------------------------------------------------------------
interface gsop_req_if import gsop_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [PORT_W-1:0] port_index;
  logic              gate_level;

  modport source (output valid, output req_type, output port_index, output gate_level,
                  input ready);
  modport sink   (input valid, input req_type, input port_index, input gate_level,
                  output ready);
endinterface

interface gsop_rsp_if import gsop_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PINS_W-1:0] pin_levels;
  logic              pins_updated;
  logic [PINS_W-1:0] strobes_active;

  modport source (output valid, output pin_levels, output pins_updated,
                  output strobes_active, input ready);
  modport sink   (input valid, input pin_levels, input pins_updated,
                  input strobes_active, output ready);
endinterface

[src/gate_and_strobe_output_ports.sv]
// ---------------------------------------------------------------------------
// gate_and_strobe_output_ports
// Bank of output pins with a gate level and a one-shot strobe per port.
// ---------------------------------------------------------------------------
// A request transfer's result is in the output register in the next cycle.
// One request per cycle while not stalled; all port counters update in parallel.
// The output register is refilled in the cycle it is emptied, so a stalled
// result only holds the request side while the result sink holds ready low.
// Reset (synchronous): levels, pins, strobes and counters cleared, width
// select 0, invert mask 0; no request is taken while reset is high.
module gate_and_strobe_output_ports import gsop_pkg::*; #(
  parameter int NUM_PORTS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  gsop_req_if.sink              req,
  gsop_rsp_if.source            rsp
);

  localparam logic [PINS_W-1:0] PortMask = PINS_W'((9'd1 << NUM_PORTS) - 9'd1);

  // configuration registers
  logic [SEL_W-1:0]  width_sel;
  logic [PINS_W-1:0] invert_mask;

  // port state
  logic [NUM_PORTS-1:0] port_levels, port_levels_next;
  logic [NUM_PORTS-1:0] latched_levels, latched_levels_next;
  logic [NUM_PORTS-1:0] strobe_marks, strobe_marks_next;
  logic [CNT_W-1:0]     strobe_remaining [NUM_PORTS];
  logic [CNT_W-1:0]     strobe_remaining_next [NUM_PORTS];
  logic [CNT_W-1:0]     cnt_dec [NUM_PORTS];

  // result register
  logic              rsp_valid;
  logic [PINS_W-1:0] pin_levels;
  logic              pins_updated;
  logic [PINS_W-1:0] strobes_active;

  logic                 req_accept;
  logic                 updated;
  logic [NUM_PORTS-1:0] port_hit;
  logic                 port_ok;
  logic [CNT_W-1:0]     load_ticks;

  // handshake
  assign req.ready  = !rst && (!rsp_valid || rsp.ready);
  assign req_accept = req.valid && req.ready;

  // configuration writes, out-of-range width selections are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      width_sel   <= '0;
      invert_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH_SEL: begin
          if (cfg_wdata < CFG_DATA_W'(WIDTH_SEL_COUNT)) begin
            width_sel <= cfg_wdata[SEL_W-1:0];
          end
        end
        CFG_INVERT_MASK: invert_mask <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // port decode and per-port counter decrement
  for (genvar n = 0; n < NUM_PORTS; n++) begin : g_port
    assign port_hit[n] = (req.port_index == PORT_W'(n));
    assign cnt_dec[n]  = (strobe_remaining[n] == '0) ? '0 : strobe_remaining[n] - 1'b1;
  end

  assign port_ok    = |port_hit;
  assign load_ticks = strobe_ticks(width_sel);

  // next port state for the presented request
  always_comb begin
    port_levels_next      = port_levels;
    latched_levels_next   = latched_levels;
    strobe_marks_next     = strobe_marks;
    strobe_remaining_next = strobe_remaining;
    updated               = 1'b0;
    case (req_type_t'(req.req_type))
      REQ_TICK: begin
        // drive pending levels, then count strobes down
        updated             = (port_levels != latched_levels);
        latched_levels_next = port_levels;
        for (int n = 0; n < NUM_PORTS; n++) begin
          if (strobe_marks[n]) begin
            strobe_remaining_next[n] = cnt_dec[n];
            if (cnt_dec[n] == '0) begin
              strobe_marks_next[n] = 1'b0;
              port_levels_next[n]  = 1'b0;
            end
          end
        end
      end
      REQ_GATE: begin
        if (port_ok) begin
          port_levels_next    = req.gate_level ? (port_levels | port_hit)
                                               : (port_levels & ~port_hit);
          updated             = (port_levels_next != latched_levels);
          latched_levels_next = port_levels_next;
        end
      end
      REQ_STROBE: begin
        if (port_ok) begin
          port_levels_next  = port_levels | port_hit;
          strobe_marks_next = strobe_marks | port_hit;
          for (int n = 0; n < NUM_PORTS; n++) begin
            if (port_hit[n]) begin
              strobe_remaining_next[n] = load_ticks;
            end
          end
          updated             = (port_levels_next != latched_levels);
          latched_levels_next = port_levels_next;
        end
      end
      default: ;
    endcase
  end

  // port state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      port_levels    <= '0;
      latched_levels <= '0;
      strobe_marks   <= '0;
      for (int n = 0; n < NUM_PORTS; n++) begin
        strobe_remaining[n] <= '0;
      end
    end else if (req_accept) begin
      port_levels      <= port_levels_next;
      latched_levels   <= latched_levels_next;
      strobe_marks     <= strobe_marks_next;
      strobe_remaining <= strobe_remaining_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      pin_levels     <= (PINS_W'(latched_levels_next) ^ invert_mask) & PortMask;
      pins_updated   <= updated;
      strobes_active <= PINS_W'(strobe_marks_next);
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.pin_levels     = pin_levels;
  assign rsp.pins_updated   = pins_updated;
  assign rsp.strobes_active = strobes_active;

endmodule

[src/gsop_checker.sv]
// ---------------------------------------------------------------------------
// gsop_checker
// Port-level checks of the gate and strobe output port bank.
// ---------------------------------------------------------------------------
module gsop_checker import gsop_pkg::*; #(
  parameter int NUM_PORTS = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic [TYPE_W-1:0] req_type,
  input logic [PORT_W-1:0] port_index,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [PINS_W-1:0] pin_levels,
  input logic              pins_updated,
  input logic [PINS_W-1:0] strobes_active
);

  logic req_xfer;
  logic port_in_range;

  assign req_xfer      = req_valid && req_ready;
  assign port_in_range = (32'(port_index) < NUM_PORTS);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pin_levels)
      && $stable(pins_updated) && $stable(strobes_active))
    else $error("result changed while stalled");

  // every request transfer gives a result on the next cycle
  a_req_to_rsp: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> rsp_valid)
    else $error("request transfer without result");

  // a strobe fire leaves its port marked active
  a_strobe_marks: assert property (@(posedge clk) disable iff (rst)
    req_xfer && req_type == REQ_STROBE && port_in_range
      |=> strobes_active[$past(port_index)])
    else $error("strobe fire did not mark its port");

  // an unknown request or out-of-range port never drives the pins
  a_no_drive: assert property (@(posedge clk) disable iff (rst)
    req_xfer && (req_type == REQ_UNUSED || (req_type != REQ_TICK && !port_in_range))
      |=> !pins_updated)
    else $error("ignored request drove the pins");

  // ports beyond the bank never show as active
  a_unused_ports: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((strobes_active >> NUM_PORTS) == '0) && ((pin_levels >> NUM_PORTS) == '0))
    else $error("unused port shows a level or strobe");

endmodule

bind gate_and_strobe_output_ports gsop_checker #(.NUM_PORTS(NUM_PORTS)) u_gsop_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_type       (req.req_type),
  .port_index     (req.port_index),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .pin_levels     (rsp.pin_levels),
  .pins_updated   (rsp.pins_updated),
  .strobes_active (rsp.strobes_active)
);

[dv/tb.sv]
// ---------------------------------------------------------------------------
// tb: testbench of gate_and_strobe_output_ports
// Feeds ticks, gate writes and strobe fires through the request channel and
// checks each result against the expected value of a directed row or a
// cycle-free model of the pin bank: port levels, latched pins, strobe marks
// and counters. A short directed table comes first, then random traffic under
// several width and polarity settings, with random gaps on both channels, one
// long result hold-off and one phase with no gaps at all.
// ---------------------------------------------------------------------------
module tb;
  import gsop_pkg::*;

  localparam int NPORTS      = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 144;
  localparam int HOLD_CYCLES = 60;
  localparam int DIR_N       = 26;

  typedef struct packed {
    logic [PINS_W-1:0] pins;
    logic              updated;
    logic [PINS_W-1:0] strobes;
  } pin_result_t;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic              level;
    logic              typed;
    pin_result_t       want;
  } dir_row_t;

  // directed rows, all under the reset settings (length 5, no inversion)
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h00, 1'b0, 8'h00}},
    '{REQ_GATE,   3'd7, 1'b1, 1'b1, '{8'h80, 1'b1, 8'h00}},
    '{REQ_GATE,   3'd7, 1'b1, 1'b1, '{8'h80, 1'b0, 8'h00}},
    '{REQ_GATE,   3'd7, 1'b0, 1'b1, '{8'h00, 1'b1, 8'h00}},
    '{REQ_GATE,   3'd0, 1'b1, 1'b1, '{8'h01, 1'b1, 8'h00}},
    '{REQ_STROBE, 3'd0, 1'b0, 1'b1, '{8'h01, 1'b0, 8'h01}},
    '{REQ_STROBE, 3'd3, 1'b1, 1'b1, '{8'h09, 1'b1, 8'h09}},
    '{REQ_UNUSED, 3'd5, 1'b1, 1'b1, '{8'h09, 1'b0, 8'h09}},
    '{REQ_GATE,   3'd3, 1'b0, 1'b1, '{8'h01, 1'b1, 8'h09}},
    '{REQ_GATE,   3'd3, 1'b1, 1'b1, '{8'h09, 1'b1, 8'h09}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h09, 1'b0, 8'h09}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h09, 1'b0, 8'h09}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h09, 1'b0, 8'h09}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h09, 1'b0, 8'h09}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h09, 1'b0, 8'h00}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h00, 1'b1, 8'h00}},
    '{REQ_STROBE, 3'd6, 1'b0, 1'b1, '{8'h40, 1'b1, 8'h40}},
    '{REQ_GATE,   3'd6, 1'b0, 1'b1, '{8'h00, 1'b1, 8'h40}},
    '{REQ_UNUSED, 3'd0, 1'b0, 1'b1, '{8'h00, 1'b0, 8'h40}},
    '{REQ_STROBE, 3'd7, 1'b1, 1'b1, '{8'h80, 1'b1, 8'hc0}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b1, '{8'h80, 1'b0, 8'hc0}},
    '{REQ_TICK,   3'd2, 1'b1, 1'b0, '{8'h00, 1'b0, 8'h00}},
    '{REQ_TICK,   3'd4, 1'b0, 1'b0, '{8'h00, 1'b0, 8'h00}},
    '{REQ_TICK,   3'd1, 1'b1, 1'b0, '{8'h00, 1'b0, 8'h00}},
    '{REQ_TICK,   3'd6, 1'b0, 1'b0, '{8'h00, 1'b0, 8'h00}},
    '{REQ_TICK,   3'd0, 1'b0, 1'b0, '{8'h00, 1'b0, 8'h00}}
  };

  // width select and invert mask per random phase; selects above four are dropped
  localparam logic [CFG_DATA_W-1:0] PHASE_SEL [PHASES] = '{
    8'd4, 8'd7, 8'd0, 8'd1, 8'd5, 8'd2, 8'd3, 8'd6
  };
  localparam logic [CFG_DATA_W-1:0] PHASE_INV [PHASES] = '{
    8'hff, 8'h00, 8'ha5, 8'h5a, 8'h0f, 8'hf0, 8'h3c, 8'h80
  };

  // strobe length per width select
  localparam logic [CNT_W-1:0] LEN_TICKS [WIDTH_SEL_COUNT] = '{
    5'd5, 5'd10, 5'd15, 5'd20, 5'd25
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gsop_req_if req_ch ();
  gsop_rsp_if rsp_ch ();

  gate_and_strobe_output_ports #(.NUM_PORTS(NPORTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // model state of the pin bank
  logic [PINS_W-1:0] port_lvl;
  logic [PINS_W-1:0] pins_latched;
  logic [PINS_W-1:0] strobe_on;
  logic [CNT_W-1:0]  strobe_left [NPORTS];
  logic [SEL_W-1:0]  len_sel;
  logic [PINS_W-1:0] pin_invert;

  pin_result_t pin_results_due [$];
  pin_result_t head;
  int          fails;
  bit          quiet;
  bit          hold_req;

  always #5 clk = ~clk;

  // ending the run if the traffic never drains
  initial begin
    #500000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fails++;
  endtask

  // drive the pins when the levels moved since the last drive
  function automatic logic latch_levels();
    if (port_lvl == pins_latched) return 1'b0;
    pins_latched = port_lvl;
    return 1'b1;
  endfunction

  // advance the model by one request and work out its result
  task automatic step_ports(input logic [TYPE_W-1:0] kind, input logic [PORT_W-1:0] port,
                            input logic level, output pin_result_t res);
    logic upd;
    int   n;
    upd = 1'b0;
    if (kind == REQ_TICK) begin
      upd = latch_levels();
      for (n = 0; n < NPORTS; n++) begin
        if (strobe_on[n]) begin
          if (strobe_left[n] != '0) strobe_left[n] = strobe_left[n] - 1'b1;
          if (strobe_left[n] == '0) begin
            strobe_on[n] = 1'b0;
            port_lvl[n]  = 1'b0;
          end
        end
      end
    end else if (kind == REQ_GATE || kind == REQ_STROBE) begin
      if (kind == REQ_GATE) begin
        port_lvl[port] = level;
      end else begin
        port_lvl[port]    = 1'b1;
        strobe_on[port]   = 1'b1;
        strobe_left[port] = LEN_TICKS[len_sel];
      end
      upd = latch_levels();
    end
    res.pins    = pins_latched ^ pin_invert;
    res.updated = upd;
    res.strobes = strobe_on;
  endtask

  // offer one request, wait for its transfer, then log what it should give
  task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [PORT_W-1:0] port,
                              input logic level, input logic typed, input pin_result_t want);
    pin_result_t res;
    if (!quiet && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.port_index <= port;
    req_ch.gate_level <= level;
    do @(posedge clk); while (!req_ch.ready);
    step_ports(kind, port, level, res);
    pin_results_due.push_back(typed ? want : res);
  endtask

  // stop offering and let every result come back
  task automatic drain_results();
    int w;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (w = 0; w < 2000 && pin_results_due.size() != 0; w++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH_SEL) begin
      if (data < WIDTH_SEL_COUNT) len_sel = data[SEL_W-1:0];
    end else begin
      pin_invert = data;
    end
  endtask

  // result side: back-pressure, with one long hold-off on request
  initial begin
    int i;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        for (i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(99) < 11) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pin_results_due.size() == 0) begin
        flag_mismatch("result with nothing due, pins", rsp_ch.pin_levels, 0);
      end else begin
        head = pin_results_due.pop_front();
        if (rsp_ch.pin_levels !== head.pins)
          flag_mismatch("pin_levels", rsp_ch.pin_levels, head.pins);
        if (rsp_ch.pins_updated !== head.updated)
          flag_mismatch("pins_updated", rsp_ch.pins_updated, head.updated);
        if (rsp_ch.strobes_active !== head.strobes)
          flag_mismatch("strobes_active", rsp_ch.strobes_active, head.strobes);
      end
    end
  end

  // main sequence
  initial begin
    int                p;
    int                k;
    int                sent;
    int                r;
    logic [TYPE_W-1:0] kind;
    pin_result_t       none;

    clk               = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_WIDTH_SEL;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TICK;
    req_ch.port_index = '0;
    req_ch.gate_level = 1'b0;
    rsp_ch.ready      = 1'b0;
    fails             = 0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    none              = '0;

    port_lvl     = '0;
    pins_latched = '0;
    strobe_on    = '0;
    len_sel      = '0;
    pin_invert   = '0;
    for (k = 0; k < NPORTS; k++) strobe_left[k] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (k = 0; k < DIR_N; k++)
      send_request(DIR_ROWS[k].kind, DIR_ROWS[k].port, DIR_ROWS[k].level,
                   DIR_ROWS[k].typed, DIR_ROWS[k].want);

    // random phases, each under its own settings
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_reg(CFG_WIDTH_SEL, PHASE_SEL[p]);
      write_reg(CFG_INVERT_MASK, PHASE_INV[p]);
      quiet = (p == 3);
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 2 && sent == 20) hold_req = 1'b1;
        r = $urandom_range(99);
        if (r < 44)      kind = REQ_TICK;
        else if (r < 68) kind = REQ_GATE;
        else if (r < 94) kind = REQ_STROBE;
        else             kind = REQ_UNUSED;
        send_request(kind, PORT_W'($urandom_range(NPORTS - 1)), 1'($urandom_range(1)),
                     1'b0, none);
        sent++;
      end
    end
    quiet = 1'b0;

    // wind down and give the verdict
    drain_results();
    if (pin_results_due.size() != 0)
      flag_mismatch("results never returned", pin_results_due.size(), 0);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
